### hw/rtl/mtlu_pkg.sv
`timescale 1ns / 1ps
package mtlu_pkg;
	localparam int MaxLeaves = 1024;
	localparam int NodeAw = 12;
	localparam int TagAw = 11;

	typedef enum logic [1:0] {
		OP_UPDATE  = 2'd0,
		OP_STORE   = 2'd1,
		OP_REBUILD = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_BLK1,
		ST_BLK2,
		ST_STORE,
		ST_NEXT,
		ST_ROOT,
		ST_ROOTW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        start;
		logic        second;
		logic [511:0] block;
	} sha_req_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sha_k(input logic [5:0] t);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		sha_k = k[t];
	endfunction
endpackage

### hw/rtl/mtlu_sha_core.sv
`timescale 1ns / 1ps
module mtlu_sha_core
	import mtlu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  sha_req_t     req,
	output logic         done,
	output logic [255:0] digest
);
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, k_q;
	logic [5:0]  t_q;
	logic        run_q;
	logic        fin_q;
	logic [31:0] t1, t2, s0, s1, wn;
	logic [31:0] iv [8];

	assign iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
		t1 = k_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25)) +
			((e_q & f_q) ^ (~e_q & g_q)) + sha_k(t_q) + w_q[0];
		t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22)) +
			((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			t_q   <= '0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				t_q   <= '0;
			end else if (run_q) begin
				t_q <= t_q + 6'd1;
				if (t_q == 6'd63) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			for (int i = 0; i < 16; i++) w_q[i] <= req.block[511 - 32 * i -: 32];
			if (!req.second) begin
				for (int i = 0; i < 8; i++) h_q[i] <= iv[i];
				{a_q, b_q, c_q, d_q} <= {iv[0], iv[1], iv[2], iv[3]};
				{e_q, f_q, g_q, k_q} <= {iv[4], iv[5], iv[6], iv[7]};
			end else begin
				{a_q, b_q, c_q, d_q} <= {h_q[0], h_q[1], h_q[2], h_q[3]};
				{e_q, f_q, g_q, k_q} <= {h_q[4], h_q[5], h_q[6], h_q[7]};
			end
		end else if (run_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wn;
			k_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end else if (fin_q) begin
			h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
			h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + k_q;
		end
	end

	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= fin_q;
	end
	assign done = done_q;
	assign digest = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
endmodule

### hw/rtl/merkle_tree_leaf_update.sv
`timescale 1ns / 1ps
// sha-256 hash tree over 2^leaves_log2 leaves of 128-bit tags
// request: pulse start with operation, leaf_index, tag_high, tag_low while busy is low
// busy stays high until the result strobe; result on root_word0..3, index_error
// for exactly one cycle with done high; the receiver cannot stall
// config: apb port, register 0 = leaves_log2 at byte address 0, write while idle
// each inner node goes through one shared sha round unit:
// the two child reads, two compressions, one store, one step
// store only, bad index or no-op: strobe after the fetch, root read and done states
// path update: one inner node per level, from the leaf's parent up to the root
// rebuild: all N - 1 inner nodes, from the last one down to the root
// one request at a time: the next is taken once busy is low again
// the root is read back from node memory before the strobe
// reset clears control and sets leaves_log2 to 10; node and tag memories
// hold no defined value until written
module merkle_tree_leaf_update
	import mtlu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [9:0]  leaf_index,
	input  logic [63:0] tag_high,
	input  logic [63:0] tag_low,
	output logic        done,
	output logic [63:0] root_word0,
	output logic [63:0] root_word1,
	output logic [63:0] root_word2,
	output logic [63:0] root_word3,
	output logic        index_error,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [3:0]  lg_q;
	logic [10:0] n;
	logic [3:0]  lgx;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {28'd0, lg_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lg_q <= 4'd10;
		else if (psel && penable && pwrite && paddr == 2'd0) lg_q <= pwdata[3:0];
	end

	always_comb begin
		lgx = lg_q;
		if (lgx == 4'd0) lgx = 4'd1;
		if (lgx > 4'd10) lgx = 4'd10;
		n = 11'd1 << lgx;
	end

	state_t      st_q, st_d;
	op_t         op_q;
	logic [9:0]  idx_q;
	logic [63:0] tag_high_q, tag_low_q;
	logic [10:0] p_q;
	logic        side_q;
	logic [255:0] left_q, right_q;
	logic        err_q;
	logic        done_q;
	logic [255:0] root_q;
	logic [1:0]  cnt_q;
	logic [255:0] digest;
	logic        sha_done;
	sha_req_t    req;
	logic [10:0] child;
	logic        child_leaf;
	logic [10:0] leaf_no;

	// node memory: 1023 nodes x 256 bits, tag memory: 1024 leaves x 128 bits
	logic [255:0] node_mem [MaxLeaves - 1];
	logic [127:0] tag_mem [MaxLeaves];
	logic [255:0] node_rd_q;
	logic [127:0] tag_rd_q;
	logic [9:0]   node_ra, node_wa;
	logic         node_we;
	logic [9:0]   tag_ra;
	logic         tag_we;
	logic [9:0]   tag_wa;
	logic [255:0] node_rd_q_sel;

	always_ff @(posedge clk) begin
		if (node_we) node_mem[node_wa] <= digest;
		node_rd_q <= node_mem[node_ra];
	end
	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[tag_wa] <= {tag_high_q, tag_low_q};
		tag_rd_q <= tag_mem[tag_ra];
	end

	assign child = {p_q[9:0], 1'b0} + 11'd1 + {10'd0, side_q};
	assign child_leaf = child >= n - 11'd1;
	assign leaf_no = child - (n - 11'd1);
	assign node_ra = (st_q == ST_ROOT) ? 10'd0 : child[9:0];
	assign tag_ra = leaf_no[9:0];
	assign node_wa = p_q[9:0];
	assign tag_wa = idx_q;
	assign node_rd_q_sel = child_leaf ? {tag_rd_q, 128'd0} : node_rd_q;

	mtlu_sha_core u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (sha_done),
		.digest (digest)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (start) st_d = ST_FETCH;
			ST_FETCH: begin
				priority if (op_q == OP_REBUILD) st_d = (n == 11'd1) ? ST_ROOT : ST_LOAD;
				else if (op_q == OP_NONE || {1'b0, idx_q} >= n) st_d = ST_ROOT;
				else if (op_q == OP_STORE) st_d = ST_ROOT;
				else st_d = ST_LOAD;
			end
			ST_LOAD:  if (side_q && cnt_q == 2'd2) st_d = ST_BLK1;
			ST_BLK1:  if (sha_done) st_d = ST_BLK2;
			ST_BLK2:  if (sha_done) st_d = ST_STORE;
			ST_STORE: st_d = ST_NEXT;
			ST_NEXT:  st_d = (p_q == 11'd0) ? ST_ROOT : ST_LOAD;
			ST_ROOT:  st_d = ST_ROOTW;
			ST_ROOTW: st_d = ST_DONE;
			ST_DONE:  st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req = '{start: 1'b0, second: 1'b0, block: '0};
		node_we = 1'b0;
		tag_we = 1'b0;
		unique case (st_q)
			ST_FETCH: tag_we = (op_q == OP_UPDATE || op_q == OP_STORE) && ({1'b0, idx_q} < n);
			ST_LOAD:  if (side_q && cnt_q == 2'd2) req = '{start: 1'b1, second: 1'b0,
				block: {left_q, node_rd_q_sel}};
			ST_BLK1:  if (sha_done) req = '{start: 1'b1, second: 1'b1,
				block: {8'h80, 494'd0, 10'd512}};
			ST_STORE: node_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= st_q == ST_DONE;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (start) begin
				op_q       <= op_t'(operation);
				idx_q      <= leaf_index;
				tag_high_q <= tag_high;
				tag_low_q  <= tag_low;
			end
			ST_FETCH: begin
				err_q  <= (op_q == OP_UPDATE || op_q == OP_STORE) && ({1'b0, idx_q} >= n);
				side_q <= 1'b0;
				cnt_q  <= 2'd0;
				if (op_q == OP_REBUILD) p_q <= n - 11'd2;
				else p_q <= (n + {1'b0, idx_q} - 11'd2) >> 1;
			end
			ST_LOAD: begin
				if (cnt_q == 2'd2) begin
					cnt_q <= 2'd0;
					if (!side_q) begin
						left_q <= node_rd_q_sel;
						side_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q + 2'd1;
				end
			end
			ST_NEXT: begin
				side_q <= 1'b0;
				cnt_q  <= 2'd0;
				if (op_q == OP_REBUILD) p_q <= p_q - 11'd1;
				else p_q <= (p_q - 11'd1) >> 1;
			end
			ST_ROOTW: root_q <= node_rd_q;
			default: ;
		endcase
	end

	assign busy = st_q != ST_IDLE;
	assign done = done_q;
	assign root_word0 = root_q[255:192];
	assign root_word1 = root_q[191:128];
	assign root_word2 = root_q[127:64];
	assign root_word3 = root_q[63:0];
	assign index_error = err_q;
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import mtlu_pkg::*;

	localparam int IdleLimit = 1000000;

	typedef struct {
		logic [255:0] root;
		logic         err;
		bit           root_known;
	} root_exp_t;

	class root_scoreboard;
		logic [255:0] node_mem [MaxLeaves-1];
		logic [127:0] leaf_mem [MaxLeaves];
		bit           node_wr  [MaxLeaves-1];
		bit           leaf_wr  [MaxLeaves];
		logic [3:0]   lg;
		root_exp_t    exp_q [$];
		int           fails;

		function new();
			lg = 4'd10;
			fails = 0;
			foreach (node_wr[i]) node_wr[i] = 0;
			foreach (leaf_wr[i]) leaf_wr[i] = 0;
		endfunction

		function int leaf_cnt();
			int n;
			n = 1 << ((lg == 0) ? 1 : lg);
			while (n > MaxLeaves) n = n >> 1;
			return n;
		endfunction

		function logic [31:0] rr(logic [31:0] x, int s);
			return (x >> s) | (x << (32 - s));
		endfunction

		function logic [255:0] compress(logic [255:0] hin, logic [511:0] blk);
			logic [31:0] w [64];
			logic [31:0] h [8];
			logic [31:0] v [8];
			logic [31:0] t1, t2, s0, s1;
			for (int i = 0; i < 8; i++) h[i] = hin[255-32*i -: 32];
			for (int t = 0; t < 16; t++) w[t] = blk[511-32*t -: 32];
			for (int t = 16; t < 64; t++) begin
				s0 = rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3);
				s1 = rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10);
				w[t] = w[t-16] + s0 + w[t-7] + s1;
			end
			v = h;
			for (int t = 0; t < 64; t++) begin
				t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25)) +
					((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_k(6'(t)) + w[t];
				t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22)) +
					((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) hin[255-32*i -: 32] = h[i] + v[i];
			return hin;
		endfunction

		function logic [255:0] child_val(int c, int n);
			if (c < n - 1) return node_mem[c];
			return {leaf_mem[c-(n-1)], 128'b0};
		endfunction

		function bit readable(int c, int n);
			if (c < n - 1) return node_wr[c];
			return leaf_wr[c-(n-1)];
		endfunction

		function void rehash(int p, int n);
			logic [255:0] hv;
			hv = compress(256'h6a09e667bb67ae853c6ef372a54ff53a510e527f9b05688c1f83d9ab5be0cd19,
				{child_val(2*p+1, n), child_val(2*p+2, n)});
			node_mem[p] = compress(hv, {8'h80, 440'b0, 64'd512});
			node_wr[p] = 1;
		endfunction

		function bit path_ok(int idx);
			int n, c;
			n = leaf_cnt();
			c = n - 1 + idx;
			while (c > 0) begin
				if (!readable((c % 2 == 1) ? c + 1 : c - 1, n)) return 0;
				c = (c - 1) / 2;
			end
			return 1;
		endfunction

		function bit rebuild_ok();
			for (int i = 0; i < leaf_cnt(); i++) if (!leaf_wr[i]) return 0;
			return 1;
		endfunction

		function bit inner_done();
			for (int i = 0; i < leaf_cnt() - 1; i++) if (!node_wr[i]) return 0;
			return 1;
		endfunction

		function void note(op_t op, int idx, logic [63:0] th, logic [63:0] tl);
			root_exp_t e;
			int n, p;
			n = leaf_cnt();
			e.err = 0;
			if (op == OP_UPDATE || op == OP_STORE) begin
				if (idx >= n) e.err = 1;
				else begin
					leaf_mem[idx] = {th, tl};
					leaf_wr[idx] = 1;
					if (op == OP_UPDATE) begin
						p = (n - 2 + idx) / 2;
						forever begin
							rehash(p, n);
							if (p == 0) break;
							p = (p - 1) / 2;
						end
					end
				end
			end else if (op == OP_REBUILD) begin
				for (p = n - 2; p >= 0; p--) rehash(p, n);
			end
			e.root = node_mem[0];
			e.root_known = node_wr[0];
			exp_q.push_back(e);
		endfunction

		function void check(logic [255:0] root, logic err);
			root_exp_t e;
			if (exp_q.size() == 0) begin
				$display("%t: result with nothing expected root=%h err=%b", $time, root, err);
				fails++;
				return;
			end
			e = exp_q.pop_front();
			if (e.root_known && root !== e.root) begin
				$display("%t: root mismatch expected %h actual %h", $time, e.root, root);
				fails++;
			end
			if (err !== e.err) begin
				$display("%t: index_error mismatch expected %b actual %b", $time, e.err, err);
				fails++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [1:0]  operation = 0;
	logic [9:0]  leaf_index = 0;
	logic [63:0] tag_high = 0;
	logic [63:0] tag_low = 0;
	logic        done;
	logic [63:0] root_word0, root_word1, root_word2, root_word3;
	logic        index_error;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [1:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;

	root_scoreboard sb = new();
	int fails = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	merkle_tree_leaf_update dut (.*);

	initial forever #1 clk = ~clk;

	always @(posedge clk) begin
		if (done) sb.check({root_word0, root_word1, root_word2, root_word3}, index_error);
		if (done || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_request(op_t op, int idx, logic [63:0] th, logic [63:0] tl);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			burst_left = $urandom_range(1, 12);
		end
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		operation <= op;
		leaf_index <= idx[9:0];
		tag_high <= th;
		tag_low <= tl;
		do @(posedge clk); while (busy);
		sb.note(op, idx, th, tl);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (sb.exp_q.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_leaves_log2(logic [3:0] value);
		@(posedge clk);
		psel <= 1; pwrite <= 1; paddr <= 0; pwdata <= {28'b0, value}; penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		sb.lg = value;
		pwrite <= 0; penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		if (prdata[3:0] !== value) begin
			$display("%t: leaves_log2 readback expected %h actual %h", $time, value, prdata[3:0]);
			fails++;
		end
		psel <= 0; penable <= 0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		logic [3:0] settings [7] = '{4'd1, 4'd10, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2};
		int n, r, idx;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);
		foreach (settings[s]) begin
			write_leaves_log2(settings[s]);
			n = sb.leaf_cnt();
			// small trees: fill the leaves, then rebuild so every node is defined
			if (n <= 64) begin
				for (int i = 0; i < n; i++)
					if (!sb.leaf_wr[i])
						send_request(OP_STORE, i, (i == 0) ? '1 : rnd64(),
							(i == 0) ? '1 : rnd64());
				send_request(OP_REBUILD, $urandom_range(0, 1023), 0, 0);
			end
			send_request(OP_NONE, $urandom_range(0, 1023), rnd64(), rnd64());
			if (n < MaxLeaves) begin
				send_request(OP_UPDATE, n, rnd64(), rnd64());
				send_request(OP_STORE, 1023, rnd64(), rnd64());
			end
			send_request(sb.path_ok(0) ? OP_UPDATE : OP_STORE, 0, 64'h0, 64'h0);
			send_request(sb.path_ok(n - 1) ? OP_UPDATE : OP_STORE, n - 1, '1, '1);
			send_request(OP_STORE, n - 1, 64'h8000000000000001, 64'h0123456789abcdef);
			for (int k = 0; k < 50; k++) begin
				r = $urandom_range(0, 99);
				idx = $urandom_range(0, n - 1);
				if (r < 60 && sb.path_ok(idx)) send_request(OP_UPDATE, idx, rnd64(), rnd64());
				else if (r < 75) send_request(OP_STORE, idx, rnd64(), rnd64());
				else if (r < 82) send_request(OP_NONE, $urandom_range(0, 1023), rnd64(), rnd64());
				else if (r < 90 && n < MaxLeaves)
					send_request(r[0] ? OP_STORE : OP_UPDATE, $urandom_range(n, 1023), rnd64(), rnd64());
				else if (n <= 32 && sb.rebuild_ok())
					send_request(OP_REBUILD, $urandom_range(0, 1023), rnd64(), rnd64());
				else send_request(sb.path_ok(idx) ? OP_UPDATE : OP_STORE, idx, rnd64(), rnd64());
			end
			drain();
		end
		fails += sb.fails;
		if (fails == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule
